>>> rtl/slc_pkg.sv
`timescale 1ns / 1ps

package slc_pkg;

	// Window of previous bytes; together with the current byte it covers keywords
	// of up to HIST_BYTES characters.
	localparam int WINDOW_DEPTH = 17;
	localparam int HIST_BYTES   = WINDOW_DEPTH + 1;
	localparam int HIST_BITS    = 8 * HIST_BYTES;
	localparam int LEN_W        = $clog2(HIST_BYTES + 1);

	// Default depth of the queue between the front and the back.
	localparam int SLC_QUEUE_DEPTH = 2;

	// Pattern classes, used as bit positions in the hit vector.
	localparam int CLASS_COUNT = 4;
	localparam logic [1:0] CLS_WGSL = 2'd0;
	localparam logic [1:0] CLS_MSL  = 2'd1;
	localparam logic [1:0] CLS_HLSL = 2'd2;
	localparam logic [1:0] CLS_GLSL = 2'd3;

	// Language codes of the result word.
	localparam logic [2:0] LANG_UNKNOWN = 3'd0;
	localparam logic [2:0] LANG_SPIRV   = 3'd1;
	localparam logic [2:0] LANG_WGSL    = 3'd2;
	localparam logic [2:0] LANG_MSL     = 3'd3;
	localparam logic [2:0] LANG_HLSL    = 3'd4;
	localparam logic [2:0] LANG_GLSL    = 3'd5;

	// Binary magic in stream order.
	localparam logic [7:0] MAGIC_B0 = 8'h03;
	localparam logic [7:0] MAGIC_B1 = 8'h02;
	localparam logic [7:0] MAGIC_B2 = 8'h23;
	localparam logic [7:0] MAGIC_B3 = 8'h07;

	// Keyword table. Each text is right aligned, so its final character sits in
	// the low byte, matching the current byte of the history vector.
	localparam int KW_COUNT = 16;
	localparam logic [HIST_BITS-1:0] KW_TEXT [KW_COUNT] = '{
		HIST_BITS'("@compute"),
		HIST_BITS'("@vertex"),
		HIST_BITS'("@fragment"),
		HIST_BITS'("fn "),
		HIST_BITS'("kernel void"),
		HIST_BITS'("[[kernel]]"),
		HIST_BITS'("device "),
		HIST_BITS'("threadgroup "),
		HIST_BITS'("[numthreads("),
		HIST_BITS'("RWStructuredBuffer"),
		HIST_BITS'("StructuredBuffer"),
		HIST_BITS'("cbuffer "),
		HIST_BITS'("#version"),
		HIST_BITS'("layout("),
		HIST_BITS'("gl_"),
		HIST_BITS'("main()")
	};
	localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
		LEN_W'(8), LEN_W'(7), LEN_W'(9), LEN_W'(3),
		LEN_W'(11), LEN_W'(10), LEN_W'(7), LEN_W'(12),
		LEN_W'(12), LEN_W'(18), LEN_W'(16), LEN_W'(8),
		LEN_W'(8), LEN_W'(7), LEN_W'(3), LEN_W'(6)
	};
	localparam logic [1:0] KW_CLS [KW_COUNT] = '{
		CLS_WGSL, CLS_WGSL, CLS_WGSL, CLS_WGSL,
		CLS_MSL, CLS_MSL, CLS_MSL, CLS_MSL,
		CLS_HLSL, CLS_HLSL, CLS_HLSL, CLS_HLSL,
		CLS_GLSL, CLS_GLSL, CLS_GLSL, CLS_GLSL
	};

	// Classified word handed from the front to the back.
	typedef struct packed {
		logic                   present;
		logic                   last;
		logic                   magic;
		logic [CLASS_COUNT-1:0] hits;
	} slc_rec_t;

	// True when the keyword ends at the current byte (low byte of hist).
	function automatic logic kw_match(input logic [HIST_BITS-1:0] hist,
			input logic [HIST_BITS-1:0] kw, input logic [LEN_W-1:0] len);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < HIST_BYTES; k++) begin
			if (LEN_W'(k) < len && hist[8*k +: 8] != kw[8*k +: 8]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

>>> rtl/shader_language_classifier.sv
`timescale 1ns / 1ps
// Path: a last word is queued, then popped into the result register that drives out_valid.
// Throughput: one word per cycle unless in_stall; the front matches every keyword against
// the byte window at once; the back folds one word per cycle, a last one into a free output.
// Reset: arst_n clears the window, counters, flags, queue and out_valid at once.
// No result is pending after reset; the first word can be taken right away.

module shader_language_classifier
	import slc_pkg::*;
#(
	parameter int QUEUE_DEPTH = SLC_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] language,
	output logic       glsl_by_default
);

	// The front keeps the 17-byte window and the byte count, and turns each
	// accepted word into a small classified word: per-class hit bits, the
	// magic flag, and the present and last marks.
	// The queue decouples it from the back, so a stalled result does not
	// stop bytes from streaming in until the queue fills.
	// The back ORs the classified words into sticky flags and, on a last
	// word, resolves the priority into the result register.

	slc_rec_t push_rec;
	slc_rec_t pop_rec;
	logic     push;
	logic     pop;
	logic     full;
	logic     empty;
	logic     accept;

	// Stall depends only on the registered queue fill, never on out_stall.
	assign in_stall = full;
	assign accept   = in_valid && !full;

	slc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.last_byte    (last_byte),
		.push         (push),
		.push_rec     (push_rec)
	);

	slc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (empty)
	);

	slc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.empty           (empty),
		.pop_rec         (pop_rec),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.language        (language),
		.glsl_by_default (glsl_by_default)
	);

endmodule

>>> rtl/slc_front.sv
`timescale 1ns / 1ps

module slc_front
	import slc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  logic     [7:0] data_byte,
	input  logic     byte_present,
	input  logic     last_byte,
	output logic     push,
	output slc_rec_t push_rec
);

	logic [7:0]           window_q [WINDOW_DEPTH];
	logic [2:0]           count_q;
	logic [HIST_BITS-1:0] hist;
	logic [CLASS_COUNT-1:0] hits;
	logic                 magic;

	always_comb begin
		hist[7:0] = data_byte;
		for (int k = 0; k < WINDOW_DEPTH; k++) begin
			hist[8*(k+1) +: 8] = window_q[k];
		end
	end

	// All keyword comparators work side by side on the same history.
	always_comb begin
		hits = '0;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (kw_match(hist, KW_TEXT[i], KW_LEN[i])) begin
				hits[KW_CLS[i]] = 1'b1;
			end
		end
	end

	assign magic = count_q == 3'd3 && window_q[2] == MAGIC_B0 && window_q[1] == MAGIC_B1
		&& window_q[0] == MAGIC_B2 && data_byte == MAGIC_B3;

	// A bare word that is not last changes nothing, so it is not queued.
	assign push             = accept && (byte_present || last_byte);
	assign push_rec.present = byte_present;
	assign push_rec.last    = last_byte;
	assign push_rec.magic   = byte_present && magic;
	assign push_rec.hits    = byte_present ? hits : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int k = 0; k < WINDOW_DEPTH; k++) begin
				window_q[k] <= '0;
			end
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
				for (int k = 0; k < WINDOW_DEPTH; k++) begin
					window_q[k] <= '0;
				end
			end else if (byte_present) begin
				if (count_q < 3'd4) begin
					count_q <= count_q + 3'd1;
				end
				window_q[0] <= data_byte;
				for (int k = 1; k < WINDOW_DEPTH; k++) begin
					window_q[k] <= window_q[k-1];
				end
			end
		end
	end

endmodule

>>> rtl/slc_queue.sv
`timescale 1ns / 1ps

module slc_queue
	import slc_pkg::*;
#(
	parameter int DEPTH = SLC_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  slc_rec_t push_rec,
	output logic     full,
	input  logic     pop,
	output slc_rec_t pop_rec,
	output logic     empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	slc_rec_t         entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_rec = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/slc_back.sv
`timescale 1ns / 1ps

module slc_back
	import slc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  slc_rec_t   pop_rec,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] language,
	output logic       glsl_by_default
);

	logic                   seen_q;
	logic                   magic_q;
	logic [CLASS_COUNT-1:0] hit_q;
	logic                   out_valid_q;
	logic [2:0]             language_q;
	logic                   dflt_q;
	logic                   seen;
	logic                   magic;
	logic [CLASS_COUNT-1:0] hit;
	logic [2:0]             lang_next;
	logic                   dflt_next;
	logic                   out_free;

	// A non-last word only folds into the flags; a last word also needs room
	// in the output register.
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = !empty && (!pop_rec.last || out_free);

	assign seen  = seen_q || pop_rec.present;
	assign magic = magic_q || pop_rec.magic;
	assign hit   = hit_q | pop_rec.hits;

	always_comb begin
		dflt_next = 1'b0;
		if (!seen) begin
			lang_next = LANG_UNKNOWN;
		end else if (magic) begin
			lang_next = LANG_SPIRV;
		end else if (hit[CLS_WGSL]) begin
			lang_next = LANG_WGSL;
		end else if (hit[CLS_MSL]) begin
			lang_next = LANG_MSL;
		end else if (hit[CLS_HLSL]) begin
			lang_next = LANG_HLSL;
		end else if (hit[CLS_GLSL]) begin
			lang_next = LANG_GLSL;
		end else begin
			lang_next = LANG_GLSL;
			dflt_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			magic_q     <= 1'b0;
			hit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (pop_rec.last) begin
					seen_q  <= 1'b0;
					magic_q <= 1'b0;
					hit_q   <= '0;
				end else begin
					seen_q  <= seen;
					magic_q <= magic;
					hit_q   <= hit;
				end
			end
			if (pop && pop_rec.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_rec.last) begin
			language_q <= lang_next;
			dflt_q     <= dflt_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign language        = language_q;
	assign glsl_by_default = dflt_q;

endmodule

>>> rtl/slc_checker.sv
`timescale 1ns / 1ps

module slc_checker
	import slc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] language,
	input logic       glsl_by_default
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(language) && $stable(glsl_by_default))
		else $error("result changed while stalled");

	// Only defined language codes leave the block.
	a_lang_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> language <= LANG_GLSL)
		else $error("undefined language code");

	// The default flag comes only with a glsl answer.
	a_dflt_glsl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && glsl_by_default |-> language == LANG_GLSL)
		else $error("default flag without glsl");

	// An offered input word always sees a defined stall.
	a_stall_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !$isunknown(in_stall))
		else $error("input stall unknown");

endmodule

bind shader_language_classifier slc_checker u_slc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.language        (language),
	.glsl_by_default (glsl_by_default)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

// Stream-level check of the shader language classifier. Source texts are sent one byte per
// word with a last marker, and a model of the classifier kept here predicts the language word
// that each stream yields. The result side compares every accepted result word against the
// oldest prediction, field by field.

module tb_top;
	import slc_pkg::*;

	typedef logic [7:0] octet_q_t [$];

	typedef struct packed {
		logic [2:0] lang;
		logic       dflt;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       byte_present = 1'b0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] language;
	logic       glsl_by_default;

	shader_language_classifier uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.byte_present    (byte_present),
		.last_byte       (last_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.language        (language),
		.glsl_by_default (glsl_by_default)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Keyword list of the classifier, grouped by class.
	string kw_text [16] = '{
		"@compute", "@vertex", "@fragment", "fn ",
		"kernel void", "[[kernel]]", "device ", "threadgroup ",
		"[numthreads(", "RWStructuredBuffer", "StructuredBuffer", "cbuffer ",
		"#version", "layout(", "gl_", "main()"
	};
	logic [1:0] kw_class [16] = '{
		CLS_WGSL, CLS_WGSL, CLS_WGSL, CLS_WGSL,
		CLS_MSL, CLS_MSL, CLS_MSL, CLS_MSL,
		CLS_HLSL, CLS_HLSL, CLS_HLSL, CLS_HLSL,
		CLS_GLSL, CLS_GLSL, CLS_GLSL, CLS_GLSL
	};

	// Model state: window of previous bytes (entry 0 newest), saturating byte count,
	// magic flag and one hit flag per class.
	logic [7:0] window_q [17];
	logic [2:0] seen_count;
	logic       magic_seen;
	logic [3:0] class_hits;

	verdict_t expected_verdicts [$];

	int errors = 0;
	int words_offered = 0;
	int words_taken = 0;
	int results_checked = 0;
	int stalled_offers = 0;
	int streams_sent = 0;
	int lang_tally [6];

	// Idling control shared by both sides, and the long hold-off of the result side.
	bit no_idle = 1'b0;
	int hold_cycles = 0;

	function automatic void clear_classifier_state();
		for (int i = 0; i < 17; i++) begin
			window_q[i] = 8'h00;
		end
		seen_count = 3'd0;
		magic_seen = 1'b0;
		class_hits = 4'b0000;
	endfunction

	// Advances the model by one accepted word; emits is set when the word closes a stream.
	function automatic void classify_word(input logic [7:0] b, input logic present,
			input logic last, output logic emits, output verdict_t v);
		int n;
		logic ok;
		logic [7:0] have;
		emits = 1'b0;
		v = '0;
		if (present) begin
			for (int i = 0; i < 16; i++) begin
				n = kw_text[i].len();
				ok = 1'b1;
				for (int k = 0; k < n; k++) begin
					have = (k == 0) ? b : window_q[k-1];
					if (have != kw_text[i][n-1-k]) begin
						ok = 1'b0;
					end
				end
				if (ok) begin
					class_hits[kw_class[i]] = 1'b1;
				end
			end
			// The magic only counts when its final byte is the fourth byte of the stream.
			if (seen_count == 3'd3 && window_q[2] == MAGIC_B0 && window_q[1] == MAGIC_B1 &&
					window_q[0] == MAGIC_B2 && b == MAGIC_B3) begin
				magic_seen = 1'b1;
			end
			if (seen_count < 3'd4) begin
				seen_count = seen_count + 3'd1;
			end
			for (int i = 16; i > 0; i--) begin
				window_q[i] = window_q[i-1];
			end
			window_q[0] = b;
		end
		if (last) begin
			emits = 1'b1;
			if (seen_count == 3'd0) begin
				v.lang = LANG_UNKNOWN;
			end else if (magic_seen) begin
				v.lang = LANG_SPIRV;
			end else if (class_hits[CLS_WGSL]) begin
				v.lang = LANG_WGSL;
			end else if (class_hits[CLS_MSL]) begin
				v.lang = LANG_MSL;
			end else if (class_hits[CLS_HLSL]) begin
				v.lang = LANG_HLSL;
			end else if (class_hits[CLS_GLSL]) begin
				v.lang = LANG_GLSL;
			end else begin
				v.lang = LANG_GLSL;
				v.dflt = 1'b1;
			end
			clear_classifier_state();
		end
	endfunction

	// Result checking first, then prediction of the word accepted at this edge. Both sides
	// sample the handshake at the edge, before the nonblocking updates of the step land.
	always @(posedge clk) begin
		verdict_t want;
		verdict_t pred;
		logic emits;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_checked++;
				if (expected_verdicts.size() == 0) begin
					errors++;
					$display("%0t: result word with no stream pending: language %0d default %0d",
						$time, language, glsl_by_default);
				end else begin
					want = expected_verdicts.pop_front();
					if (language !== want.lang) begin
						errors++;
						$display("%0t: language expected %0d actual %0d",
							$time, want.lang, language);
					end
					if (glsl_by_default !== want.dflt) begin
						errors++;
						$display("%0t: glsl_by_default expected %0d actual %0d",
							$time, want.dflt, glsl_by_default);
					end
				end
			end
			if (in_valid && in_stall) begin
				stalled_offers++;
			end
			if (in_valid && !in_stall) begin
				words_taken++;
				classify_word(data_byte, byte_present, last_byte, emits, pred);
				if (emits) begin
					expected_verdicts.push_back(pred);
					if (pred.lang <= LANG_GLSL) begin
						lang_tally[pred.lang]++;
					end
				end
			end
		end
	end

	// Result side: random stall, or a long hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < 16);
			end
		end
	end

	// Offers one word and returns at the edge where it was taken. Must be called at a
	// rising edge; valid is only lowered for idle cycles, never within the same step.
	task automatic send_word(input logic [7:0] b, input logic present, input logic last);
		while (!no_idle && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_present <= present;
		last_byte <= last;
		words_offered++;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Sends one stream. The end is either a last flag on the final byte or a bare end marker;
	// an empty stream always ends with the bare marker. With filler set, bare filler words are sprinkled in.
	task automatic send_stream(input octet_q_t text, input bit bare_end, input bit filler);
		int n;
		n = text.size();
		for (int i = 0; i < n; i++) begin
			if (filler && $urandom_range(99) < 5) begin
				send_word(8'($urandom_range(255)), 1'b0, 1'b0);
			end
			send_word(text[i], 1'b1, (i == n - 1) && !bare_end);
		end
		if (bare_end || n == 0) begin
			send_word(8'($urandom_range(255)), 1'b0, 1'b1);
		end
		streams_sent++;
	endtask

	function automatic void add_text(ref octet_q_t q, input string s);
		for (int j = 0; j < s.len(); j++) begin
			q.push_back(s[j]);
		end
	endfunction

	function automatic void add_magic(ref octet_q_t q);
		q.push_back(MAGIC_B0);
		q.push_back(MAGIC_B1);
		q.push_back(MAGIC_B2);
		q.push_back(MAGIC_B3);
	endfunction

	// Sender pause: no word offered until every predicted result has come out, then a wait for
	// anything the block might still push out unexpectedly.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		wait (expected_verdicts.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_empty_streams();
		octet_q_t q;
		q = {};
		send_stream(q, 1'b1, 1'b0);
		// A bare word that is not last must leave the empty stream empty.
		send_word(8'hA5, 1'b0, 1'b0);
		send_stream(q, 1'b1, 1'b0);
		drain_results();
	endtask

	task automatic test_magic();
		octet_q_t q;
		q = {};
		add_magic(q);
		send_stream(q, 1'b1, 1'b0);
		// Magic outranks a keyword seen later in the same stream.
		q = {};
		add_magic(q);
		add_text(q, "fn ");
		send_stream(q, 1'b0, 1'b0);
		// Three magic bytes only: too short, falls back to the default.
		q = {MAGIC_B0, MAGIC_B1, MAGIC_B2};
		send_stream(q, 1'b0, 1'b0);
		// Magic shifted by one byte is not at the start and does not count.
		q = {8'h78};
		add_magic(q);
		send_stream(q, 1'b0, 1'b0);
		drain_results();
	endtask

	task automatic test_byte_extremes();
		octet_q_t q;
		q = {8'h00, 8'hFF};
		send_stream(q, 1'b0, 1'b0);
		q = {};
		add_text(q, "gl_");
		send_stream(q, 1'b0, 1'b0);
		drain_results();
	endtask

	// Hold the result side off while short streams keep coming, so the queue fills and
	// the input stalls; then let everything drain.
	task automatic test_backpressure();
		octet_q_t q;
		hold_cycles = 80;
		for (int s = 0; s < 12; s++) begin
			q = {8'($urandom_range(255)), 8'($urandom_range(255))};
			send_stream(q, 1'b0, 1'b0);
		end
		drain_results();
	endtask

	// Random streams built mostly from keywords, keyword prefixes and near-miss text, with
	// plain random bytes as noise and a magic at the start now and then.
	task automatic test_random_streams(input int word_goal);
		octet_q_t q;
		string s;
		string near_miss;
		int goal;
		int frags;
		int r;
		int idx;
		int stream_no;
		near_miss = " ()[]_#@abcdefghiklmnorstuvBRSW";
		goal = words_offered + word_goal;
		stream_no = 0;
		while (words_offered < goal) begin
			// A stretch of streams with no idling on either side.
			no_idle = (stream_no >= 10 && stream_no < 25);
			q = {};
			r = $urandom_range(99);
			if (r < 10) begin
				add_magic(q);
			end else if (r < 15) begin
				add_magic(q);
				q[$urandom_range(3)] = 8'($urandom_range(255));
			end
			frags = $urandom_range(4);
			for (int f = 0; f < frags; f++) begin
				r = $urandom_range(99);
				idx = $urandom_range(15);
				s = kw_text[idx];
				if (r < 40) begin
					add_text(q, s);
				end else if (r < 55) begin
					add_text(q, s.substr(0, $urandom_range(s.len() - 2)));
				end else if (r < 80) begin
					repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(255)));
				end else if (r < 92) begin
					repeat ($urandom_range(1, 6))
						q.push_back(near_miss[$urandom_range(near_miss.len() - 1)]);
				end else begin
					add_magic(q);
				end
			end
			send_stream(q, 1'($urandom_range(1)), 1'b1);
			stream_no++;
		end
		no_idle = 1'b0;
		drain_results();
	endtask

	initial begin
		clear_classifier_state();
		for (int i = 0; i < 6; i++) begin
			lang_tally[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_streams();
		test_magic();
		test_byte_extremes();
		test_backpressure();
		test_random_streams(1400);
		$display("Sent %0d streams in %0d words (%0d offers stalled), checked %0d results.",
			streams_sent, words_taken, stalled_offers, results_checked);
		$display("Results by language: unknown %0d spirv %0d wgsl %0d msl %0d hlsl %0d glsl %0d",
			lang_tally[0], lang_tally[1], lang_tally[2], lang_tally[3], lang_tally[4],
			lang_tally[5]);
		if (errors == 0 && expected_verdicts.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results outstanding", expected_verdicts.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
rtl/slc_pkg.sv
rtl/slc_front.sv
rtl/slc_queue.sv
rtl/slc_back.sv
rtl/shader_language_classifier.sv
rtl/slc_checker.sv
verif/tb_top.sv
